FILE: sv/sbm_pkg.sv
// Shared types, constants and SECDED(13,8) helper functions for the
// protected byte memory. No dependencies.
`default_nettype none

package sbm_pkg;

	localparam int unsigned DEPTH  = 256;
	localparam int unsigned ADDR_W = $clog2(DEPTH);
	localparam int unsigned DATA_W = 8;
	localparam int unsigned CHK_W  = 5;
	localparam int unsigned WORD_W = DATA_W + CHK_W;
	localparam int unsigned CW_W   = 16;

	typedef enum logic [1:0] {
		CMD_READ   = 2'd0,
		CMD_WRITE  = 2'd1,
		CMD_INJECT = 2'd2
	} command_t;

	typedef enum logic [1:0] {
		RES_CLEAN      = 2'd0,
		RES_PARITY_FIX = 2'd1,
		RES_SINGLE     = 2'd2,
		RES_DOUBLE     = 2'd3
	} result_t;

	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_EXEC = 1'b1
	} fsm_state_t;

	// Controller commands to the datapath
	typedef struct packed {
		logic capture;  // latch the input beat and launch the RAM read
		logic commit;   // write back and load the result register
	} sbm_ctl_t;

	function automatic logic [3:0] hamming_checks(input logic [DATA_W-1:0] d);
		logic [3:0] c;
		c[0] = d[0] ^ d[1] ^ d[3] ^ d[4] ^ d[6];
		c[1] = d[0] ^ d[2] ^ d[3] ^ d[5] ^ d[6];
		c[2] = d[1] ^ d[2] ^ d[3] ^ d[7];
		c[3] = d[4] ^ d[5] ^ d[6] ^ d[7];
		return c;
	endfunction

	// Spread data and check bits to codeword positions; bits 13..15 stay zero
	function automatic logic [CW_W-1:0] to_codeword(input logic [DATA_W-1:0] d,
		input logic [CHK_W-1:0] c);
		logic [CW_W-1:0] cw;
		cw      = '0;
		cw[0]   = c[4];
		cw[1]   = c[0];
		cw[2]   = c[1];
		cw[3]   = d[0];
		cw[4]   = c[2];
		cw[5]   = d[1];
		cw[6]   = d[2];
		cw[7]   = d[3];
		cw[8]   = c[3];
		cw[12:9] = d[7:4];
		return cw;
	endfunction

	function automatic logic [DATA_W-1:0] cw_data(input logic [CW_W-1:0] cw);
		return {cw[12:9], cw[7:5], cw[3]};
	endfunction

	function automatic logic [CHK_W-1:0] cw_checks(input logic [CW_W-1:0] cw);
		return {cw[0], cw[8], cw[4], cw[2], cw[1]};
	endfunction

endpackage

`default_nettype wire

FILE: sv/sbm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sbm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: sv/sbm_ctrl.sv
// Sequencing state machine for the protected byte memory: handshakes
// and command strobes. Depends on sbm_pkg.
`default_nettype none

module sbm_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output sbm_pkg::sbm_ctl_t    ctl
);

	sbm_pkg::fsm_state_t state_q, state_d;
	logic                out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sbm_pkg::FSM_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		ctl.capture = 1'b0;
		ctl.commit  = 1'b0;
		unique case (state_q)
			sbm_pkg::FSM_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.capture = 1'b1;
					state_d     = sbm_pkg::FSM_EXEC;
				end
			end
			sbm_pkg::FSM_EXEC: begin
				// hold until the result register is free
				if (!out_valid_q || out_ready) begin
					ctl.commit = 1'b1;
					state_d    = sbm_pkg::FSM_IDLE;
				end
			end
			default: state_d = sbm_pkg::FSM_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == sbm_pkg::FSM_EXEC))
		else $error("accepted beat did not move to execute");

	a_commit_only_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while still pending");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sbm_pkg::FSM_EXEC && out_valid_q && !out_ready)
		|=> (state_q == sbm_pkg::FSM_EXEC))
		else $error("execute left while output stalled");

	a_valid_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == sbm_pkg::FSM_EXEC))
		else $error("result raised without execute");

endmodule

`default_nettype wire

FILE: sv/sbm_dp.sv
// Datapath of the protected byte memory: input capture, code RAM, entry
// valid bits, SECDED encode/decode and result register. Depends on sbm_pkg, sbm_ram.
`default_nettype none

module sbm_dp (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire sbm_pkg::sbm_ctl_t            ctl,
	input  wire logic [1:0]                   command,
	input  wire logic [7:0]                   address,
	input  wire logic [sbm_pkg::DATA_W-1:0]   write_data,
	input  wire logic [3:0]                   flip_position,
	output logic      [sbm_pkg::DATA_W-1:0]   read_data,
	output logic      [1:0]                   status,
	output logic      [3:0]                   error_position
);

	logic [1:0]                   command_q;
	logic [sbm_pkg::ADDR_W-1:0]   addr_q;
	logic [sbm_pkg::DATA_W-1:0]   wdata_q;
	logic [3:0]                   fpos_q;

	logic [sbm_pkg::DEPTH-1:0]    valid_q;
	logic [sbm_pkg::WORD_W-1:0]   rd_word;
	logic [sbm_pkg::WORD_W-1:0]   word;
	logic [sbm_pkg::WORD_W-1:0]   wr_word;
	logic                         wr_en;

	logic [sbm_pkg::DATA_W-1:0]   d;
	logic [sbm_pkg::CHK_W-1:0]    stored;
	logic [3:0]                   syn;
	logic                         pw_calc;
	logic                         pbad;
	logic [sbm_pkg::CW_W-1:0]     cw;
	logic [sbm_pkg::CW_W-1:0]     cw_flip;
	logic [3:0]                   wchk;
	logic                         wpar;

	logic [sbm_pkg::DATA_W-1:0]   res_data;
	sbm_pkg::result_t             res_status;
	logic [3:0]                   res_pos;

	logic [sbm_pkg::DATA_W-1:0]   read_data_q;
	sbm_pkg::result_t             status_q;
	logic [3:0]                   error_position_q;

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			command_q <= command;
			addr_q    <= address[sbm_pkg::ADDR_W-1:0];
			wdata_q   <= write_data;
			fpos_q    <= flip_position;
		end
		if (ctl.commit) begin
			read_data_q      <= res_data;
			status_q         <= res_status;
			error_position_q <= res_pos;
		end
	end

	// An entry never written reads as the all-zero codeword
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.commit && wr_en) begin
			valid_q[addr_q] <= 1'b1;
		end
	end

	sbm_ram #(
		.WIDTH(sbm_pkg::WORD_W),
		.DEPTH(sbm_pkg::DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ctl.commit && wr_en),
		.waddr(addr_q),
		.wdata(wr_word),
		.re   (ctl.capture),
		.raddr(address[sbm_pkg::ADDR_W-1:0]),
		.rdata(rd_word)
	);

	always_comb begin
		word    = valid_q[addr_q] ? rd_word : '0;
		d       = word[sbm_pkg::DATA_W-1:0];
		stored  = word[sbm_pkg::WORD_W-1:sbm_pkg::DATA_W];
		syn     = sbm_pkg::hamming_checks(d) ^ stored[3:0];
		pw_calc = (^d) ^ (^stored[3:0]);
		pbad    = stored[4] ^ pw_calc;
		cw      = sbm_pkg::to_codeword(d, stored);
		wchk    = sbm_pkg::hamming_checks(wdata_q);
		wpar    = (^wdata_q) ^ (^wchk);
		cw_flip = '0;

		res_data   = '0;
		res_status = sbm_pkg::RES_CLEAN;
		res_pos    = '0;
		wr_en      = 1'b0;
		wr_word    = word;

		unique case (command_q)
			sbm_pkg::CMD_WRITE: begin
				wr_en   = 1'b1;
				wr_word = {wpar, wchk, wdata_q};
			end
			sbm_pkg::CMD_INJECT: begin
				// flips above position twelve land in unused bits and drop out
				cw_flip = cw ^ (sbm_pkg::CW_W'(1) << fpos_q);
				wr_en   = 1'b1;
				wr_word = {sbm_pkg::cw_checks(cw_flip), sbm_pkg::cw_data(cw_flip)};
			end
			sbm_pkg::CMD_READ: begin
				res_data = d;
				priority if (syn == 4'd0) begin
					if (pbad) begin
						res_status = sbm_pkg::RES_PARITY_FIX;
						wr_en      = 1'b1;
						wr_word    = {pw_calc, stored[3:0], d};
					end
				end else if (pbad) begin
					cw_flip    = cw ^ (sbm_pkg::CW_W'(1) << syn);
					res_status = sbm_pkg::RES_SINGLE;
					res_pos    = syn;
					res_data   = sbm_pkg::cw_data(cw_flip);
				end else begin
					res_status = sbm_pkg::RES_DOUBLE;
				end
			end
			default: begin
				res_data = '0;
			end
		endcase
	end

	assign read_data      = read_data_q;
	assign status         = status_q;
	assign error_position = error_position_q;

endmodule

`default_nettype wire

FILE: sv/secded_protected_byte_memory_unit.sv
// An accepted beat is captured and its RAM read launched; execute then decodes, writes
// back through the single-write code RAM and loads the output register once it is free;
// no new command is taken until the last one commits. A stalled output holds execute.
// Reset (arst_n low, asynchronous) clears the controller, the output valid and all
// entry valid bits at once, so every location reads as a zero byte with clean code.
// Top level; depends on sbm_pkg, sbm_ctrl, sbm_dp, sbm_ram.
`default_nettype none

module secded_protected_byte_memory_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  command,
	input  wire logic [7:0]  address,
	input  wire logic [7:0]  write_data,
	input  wire logic [3:0]  flip_position,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       read_data,
	output logic [1:0]       status,
	output logic [3:0]       error_position
);

	// Strobes from the controller: capture on input beat, commit on execute
	sbm_pkg::sbm_ctl_t ctl;

	// Controller: idle/execute sequencing and both handshakes
	sbm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.ctl      (ctl)
	);

	// Datapath: code RAM with per-entry valid bits, SECDED encode on write,
	// syndrome decode with parity repair and single-bit correction on read,
	// codeword bit flip on inject, and the result register
	sbm_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.command       (command),
		.address       (address),
		.write_data    (write_data),
		.flip_position (flip_position),
		.read_data     (read_data),
		.status        (status),
		.error_position(error_position)
	);

endmodule

`default_nettype wire

FILE: bench/secded_protected_byte_memory_unit_test.sv
// Self-checking bench for secded_protected_byte_memory_unit: writes, fault injections and
// reads against a SECDED(13,8) predictor of the stored codewords.
// Depends on sbm_pkg and the secded_protected_byte_memory_unit RTL.
`default_nettype none

module secded_protected_byte_memory_unit_test;

	// Command code the block must treat as a no-op with an all-zero reply
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int TOTAL_OPS = 1925;
	localparam int DRAIN_CYCLES = 12;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_REPORTS = 100;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] addr;
		logic [7:0] wdata;
		logic [3:0] fpos;
	} mem_op_t;

	typedef struct packed {
		logic [7:0] rdata;
		logic [1:0] status;
		logic [3:0] epos;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] command = '0;
	logic [7:0] address = '0;
	logic [7:0] write_data = '0;
	logic [3:0] flip_position = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] read_data;
	logic [1:0] status;
	logic [3:0] error_position;

	// Shadow copy of the protected memory: data byte and {parity, c3..c0}
	logic [7:0] data_mem [sbm_pkg::DEPTH];
	logic [4:0] code_mem [sbm_pkg::DEPTH];

	mem_op_t cmd_backlog[$];
	reply_t pending_replies[$];
	mem_op_t cur_op = '0;

	logic beat_taken = 1'b0;
	int send_gap = 0;
	int src_calm = 0;
	int stall_left = 0;
	int sink_calm = 0;
	int mismatches = 0;
	int cycle_count = 0;

	secded_protected_byte_memory_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.address(address),
		.write_data(write_data),
		.flip_position(flip_position),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_data(read_data),
		.status(status),
		.error_position(error_position)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Hold reset at start, release away from the rising edge
	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	initial begin
		for (int i = 0; i < sbm_pkg::DEPTH; i++) begin
			data_mem[i] = '0;
			code_mem[i] = '0;
		end
	end

	// Hamming check bits c3..c0 as parity over fixed data-bit masks
	function automatic logic [3:0] check_bits(input logic [7:0] d);
		return {^(d & 8'hF0), ^(d & 8'h8E), ^(d & 8'h6D), ^(d & 8'h5B)};
	endfunction

	// Data bit held at a codeword position, or -1
	function automatic int data_bit(input logic [3:0] pos);
		case (pos)
			4'd3: return 0;
			4'd5: return 1;
			4'd6: return 2;
			4'd7: return 3;
			4'd9: return 4;
			4'd10: return 5;
			4'd11: return 6;
			4'd12: return 7;
			default: return -1;
		endcase
	endfunction

	// Stored check bit held at a codeword position, or -1
	function automatic int code_bit(input logic [3:0] pos);
		case (pos)
			4'd0: return 4;
			4'd1: return 0;
			4'd2: return 1;
			4'd4: return 2;
			4'd8: return 3;
			default: return -1;
		endcase
	endfunction

	// Apply one command to the shadow memory and queue the reply it must produce
	function automatic void predict_access(input mem_op_t op);
		reply_t r;
		logic [7:0] d;
		logic [4:0] code;
		logic [3:0] syn;
		logic par_calc;
		int idx;
		r = '0;
		case (op.cmd)
			sbm_pkg::CMD_WRITE: begin
				data_mem[op.addr] = op.wdata;
				code_mem[op.addr] = {(^op.wdata) ^ (^check_bits(op.wdata)),
					check_bits(op.wdata)};
			end
			sbm_pkg::CMD_INJECT: begin
				idx = data_bit(op.fpos);
				if (idx >= 0) begin
					data_mem[op.addr][idx] = ~data_mem[op.addr][idx];
				end else begin
					// positions above twelve flip nothing
					idx = code_bit(op.fpos);
					if (idx >= 0)
						code_mem[op.addr][idx] = ~code_mem[op.addr][idx];
				end
			end
			sbm_pkg::CMD_READ: begin
				d = data_mem[op.addr];
				code = code_mem[op.addr];
				syn = check_bits(d) ^ code[3:0];
				par_calc = (^d) ^ (^code[3:0]);
				r.rdata = d;
				if (syn == 4'd0) begin
					// lone parity-bit fault: the block rewrites the parity bit
					if (par_calc != code[4]) begin
						r.status = sbm_pkg::RES_PARITY_FIX;
						code_mem[op.addr][4] = par_calc;
					end else begin
						r.status = sbm_pkg::RES_CLEAN;
					end
				end else if (par_calc != code[4]) begin
					// odd fault count: correct the named data bit, if any
					r.status = sbm_pkg::RES_SINGLE;
					r.epos = syn;
					idx = data_bit(syn);
					if (idx >= 0)
						r.rdata[idx] = ~d[idx];
				end else begin
					r.status = sbm_pkg::RES_DOUBLE;
				end
			end
			default: begin
				// unused code: no state change, all-zero reply
			end
		endcase
		pending_replies.push_back(r);
	endfunction

	function automatic void add_op(input logic [1:0] cmd, input logic [7:0] addr,
		input logic [7:0] wdata, input logic [3:0] fpos);
		mem_op_t op;
		op.cmd = cmd;
		op.addr = addr;
		op.wdata = wdata;
		op.fpos = fpos;
		cmd_backlog.push_back(op);
	endfunction

	// Mostly a small pool at both ends of the address space so that
	// injections and reads land on written locations
	function automatic logic [7:0] pool_addr();
		if ($urandom_range(0, 3) == 0)
			return 8'($urandom_range(0, 255));
		return {($urandom_range(0, 1) == 1) ? 4'hF : 4'h0, 4'($urandom_range(0, 15))};
	endfunction

	// Idle length: mostly short, a few long, and calm stretches with none
	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 49) == 0) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	task automatic flag_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	// Driver, sampling side: record the beat and predict its reply
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			predict_access(cur_op);
			beat_taken <= 1'b1;
		end else begin
			beat_taken <= 1'b0;
		end
	end

	// Driver, launching side: hold an unaccepted beat, else idle or advance
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !beat_taken) begin
			// hold valid and payload until the beat is taken
		end else if (send_gap > 0) begin
			in_valid <= 1'b0;
			send_gap--;
		end else if (cmd_backlog.size() > 0) begin
			cur_op = cmd_backlog.pop_front();
			command <= cur_op.cmd;
			address <= cur_op.addr;
			write_data <= cur_op.wdata;
			flip_position <= cur_op.fpos;
			in_valid <= 1'b1;
			send_gap = pick_gap(src_calm);
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Sink back-pressure: random stalls of varied length
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 99) < 30)
				stall_left = pick_gap(sink_calm);
		end
	end

	// Monitor: compare each reply beat with the oldest prediction
	always @(posedge clk) begin
		reply_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_replies.size() == 0) begin
				flag_mismatch($sformatf("reply with nothing outstanding: data %02h status %0d pos %0d",
					read_data, status, error_position));
			end else begin
				want = pending_replies.pop_front();
				if (read_data !== want.rdata)
					flag_mismatch($sformatf("read_data %02h, want %02h", read_data, want.rdata));
				if (status !== want.status)
					flag_mismatch($sformatf("status %0d, want %0d", status, want.status));
				if (error_position !== want.epos)
					flag_mismatch($sformatf("error_position %0d, want %0d",
						error_position, want.epos));
			end
		end
	end

	// Watchdog: drop the run if it hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int r;
		int nflip;
		logic [7:0] a;

		// Field extremes and untouched locations after reset
		add_op(sbm_pkg::CMD_WRITE, 8'h00, 8'h00, 4'd0);
		add_op(sbm_pkg::CMD_WRITE, 8'hFF, 8'hFF, 4'd15);
		add_op(sbm_pkg::CMD_READ, 8'hFF, 8'h00, 4'd0);
		add_op(sbm_pkg::CMD_READ, 8'h00, 8'hFF, 4'd15);
		add_op(sbm_pkg::CMD_READ, 8'h11, 8'h00, 4'd0);
		// Parity-bit fault: repaired on the first read, clean on the second
		add_op(sbm_pkg::CMD_INJECT, 8'h00, 8'h00, 4'd0);
		add_op(sbm_pkg::CMD_READ, 8'h00, 8'h00, 4'd0);
		add_op(sbm_pkg::CMD_READ, 8'h00, 8'h00, 4'd0);
		// Single data-bit fault, corrected on the way out
		add_op(sbm_pkg::CMD_WRITE, 8'h05, 8'hA5, 4'd0);
		add_op(sbm_pkg::CMD_INJECT, 8'h05, 8'h00, 4'd12);
		add_op(sbm_pkg::CMD_READ, 8'h05, 8'h00, 4'd0);
		add_op(sbm_pkg::CMD_INJECT, 8'h05, 8'h00, 4'd12);
		// Single check-bit fault, then a second fault for a double error
		add_op(sbm_pkg::CMD_INJECT, 8'h05, 8'h00, 4'd8);
		add_op(sbm_pkg::CMD_READ, 8'h05, 8'h00, 4'd0);
		add_op(sbm_pkg::CMD_INJECT, 8'h05, 8'h00, 4'd3);
		add_op(sbm_pkg::CMD_READ, 8'h05, 8'h00, 4'd0);
		// Three check-bit faults: odd parity with a syndrome past the codeword
		add_op(sbm_pkg::CMD_WRITE, 8'h09, 8'h3C, 4'd0);
		add_op(sbm_pkg::CMD_INJECT, 8'h09, 8'h00, 4'd1);
		add_op(sbm_pkg::CMD_INJECT, 8'h09, 8'h00, 4'd4);
		add_op(sbm_pkg::CMD_INJECT, 8'h09, 8'h00, 4'd8);
		add_op(sbm_pkg::CMD_READ, 8'h09, 8'h00, 4'd0);
		// Out-of-range injections and the unused code change nothing
		add_op(sbm_pkg::CMD_INJECT, 8'h09, 8'h00, 4'd15);
		add_op(sbm_pkg::CMD_INJECT, 8'h09, 8'h00, 4'd13);
		add_op(CMD_UNUSED, 8'h09, 8'hFF, 4'd15);
		add_op(sbm_pkg::CMD_READ, 8'h09, 8'h00, 4'd0);

		// Random part: mostly write / inject / read sequences, some noise
		while (cmd_backlog.size() < TOTAL_OPS) begin
			r = $urandom_range(0, 99);
			a = pool_addr();
			if (r < 75) begin
				add_op(sbm_pkg::CMD_WRITE, a, 8'($urandom), 4'($urandom));
				nflip = ($urandom_range(0, 9) < 2) ? 0 : $urandom_range(1, 3);
				for (int k = 0; k < nflip; k++)
					add_op(sbm_pkg::CMD_INJECT, a, 8'($urandom), 4'($urandom));
				add_op(sbm_pkg::CMD_READ, a, 8'($urandom), 4'($urandom));
				if ($urandom_range(0, 1) == 1)
					add_op(sbm_pkg::CMD_READ, a, 8'($urandom), 4'($urandom));
			end else if (r < 90) begin
				add_op(sbm_pkg::CMD_INJECT, a, 8'($urandom), 4'($urandom));
				add_op(sbm_pkg::CMD_READ, a, 8'($urandom), 4'($urandom));
			end else begin
				add_op(2'($urandom), a, 8'($urandom), 4'($urandom));
			end
		end

		// Wait for the last beat to go in, every reply to come back, then drain
		while (cmd_backlog.size() != 0 || in_valid)
			@(posedge clk);
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

`default_nettype wire

FILE: sim.f
sv/sbm_pkg.sv
sv/sbm_ram.sv
sv/sbm_ctrl.sv
sv/sbm_dp.sv
sv/secded_protected_byte_memory_unit.sv
bench/secded_protected_byte_memory_unit_test.sv
